FILE: hdl/qts_pkg.sv
// shared constants and types for the two-stack queue
// no dependencies; compiled first
package qts_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_MOVE
	} state_t;

endpackage

FILE: hdl/qts_req_if.sv
// request channel of the two-stack queue: valid/ready plus request payload
// depends on qts_pkg
interface qts_req_if import qts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     req_type;
	logic signed [DATA_W-1:0] data_in;

	modport source (output valid, req_type, data_in, input ready);
	modport sink   (input valid, req_type, data_in, output ready);
endinterface

FILE: hdl/qts_rsp_if.sv
// response channel of the two-stack queue: valid/ready plus result payload
// depends on qts_pkg
interface qts_rsp_if import qts_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	status_t                  status;

	modport source (output valid, data_out, status, input ready);
	modport sink   (input valid, data_out, status, output ready);
endinterface

FILE: hdl/queue_from_two_stacks.sv
// top level of the two-stack fifo queue
// depends on qts_pkg, qts_req_if, qts_rsp_if and qts_ram
//
// A first-in first-out queue of 32-bit values held as two stacks, each in its
// own ram with a registered read. An insert beat pushes onto the input stack
// and its result is ready the cycle after acceptance; a full input stack
// rejects the value with an overflow status even if the output stack has room.
// A delete beat pops the output stack; the registered ram read data is loaded
// into the output register from the pop state. When the output stack is empty,
// a delete first walks the input stack across, one entry per cycle through the
// input ram read port; each value crosses once. A delete on an empty queue
// returns an underflow status with zero data. One request is in flight at a
// time; the result sits in an output register, so the next request is taken
// in the same cycle that the pending result is taken.
module queue_from_two_stacks import qts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	qts_req_if.sink   req,
	qts_rsp_if.source rsp
);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   in_cnt_q, in_cnt_d;
	logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
	logic [CNT_W-1:0]   in_cnt_m1, out_cnt_m1;
	logic               mv_s1, mv_d;
	logic               in_full;
	logic               req_rdy;

	logic               in_we, out_we;
	logic [DATA_W-1:0]  in_rdata, out_rdata;

	logic               rsp_valid_q, rsp_load;
	logic [DATA_W-1:0]  rsp_data_q, rsp_data_d;
	status_t            rsp_status_q, rsp_status_d;

	assign in_cnt_m1  = in_cnt_q - CNT_W'(1);
	assign out_cnt_m1 = out_cnt_q - CNT_W'(1);
	assign in_full    = (in_cnt_q == CNT_W'(STACK_DEPTH));

	qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_in_ram (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_cnt_q[ADDR_W-1:0]),
		.wdata (req.data_in),
		.raddr (in_cnt_m1[ADDR_W-1:0]),
		.rdata (in_rdata)
	);

	qts_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_out_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_cnt_q[ADDR_W-1:0]),
		.wdata (in_rdata),
		.raddr (out_cnt_m1[ADDR_W-1:0]),
		.rdata (out_rdata)
	);

	always_comb begin
		state_d      = state_q;
		in_cnt_d     = in_cnt_q;
		out_cnt_d    = out_cnt_q;
		mv_d         = 1'b0;
		req_rdy      = 1'b0;
		in_we        = 1'b0;
		out_we       = 1'b0;
		rsp_load     = 1'b0;
		rsp_data_d   = '0;
		rsp_status_d = ST_OK;
		case (state_q)
			S_IDLE: begin
				req_rdy = !rsp_valid_q || rsp.ready;
				if (req.valid && req_rdy) begin
					if (req.req_type == REQ_INSERT) begin
						rsp_load = 1'b1;
						if (in_full) begin
							rsp_status_d = ST_OVERFLOW;
						end else begin
							in_we    = 1'b1;
							in_cnt_d = in_cnt_q + CNT_W'(1);
						end
					end else if (out_cnt_q != '0) begin
						// read address is count - 1, pop takes effect now
						out_cnt_d = out_cnt_m1;
						state_d   = S_POP;
					end else if (in_cnt_q != '0) begin
						state_d = S_MOVE;
					end else begin
						rsp_load     = 1'b1;
						rsp_status_d = ST_UNDERFLOW;
					end
				end
			end
			S_POP: begin
				rsp_load   = 1'b1;
				rsp_data_d = out_rdata;
				state_d    = S_IDLE;
			end
			S_MOVE: begin
				// issue next input stack read while the previous one lands
				if (in_cnt_q != '0) begin
					mv_d     = 1'b1;
					in_cnt_d = in_cnt_m1;
				end
				if (mv_s1) begin
					if (in_cnt_q != '0) begin
						out_we    = 1'b1;
						out_cnt_d = out_cnt_q + CNT_W'(1);
					end else begin
						// last entry moved is the oldest: hand it out directly
						rsp_load   = 1'b1;
						rsp_data_d = in_rdata;
						state_d    = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			mv_s1     <= 1'b0;
		end else begin
			state_q   <= state_d;
			in_cnt_q  <= in_cnt_d;
			out_cnt_q <= out_cnt_d;
			mv_s1     <= mv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_data_q   <= rsp_data_d;
			rsp_status_q <= rsp_status_d;
		end
	end

	assign req.ready    = req_rdy;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.data_out = rsp_data_q;
	assign rsp.status   = rsp_status_q;

endmodule

FILE: hdl/qts_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module qts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/qts_chk.sv
// port-level checker for the two-stack queue, bound to the top level
// depends on qts_pkg and queue_from_two_stacks
module qts_chk import qts_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] rsp_data,
	input status_t           rsp_status
);

	logic [1:0] pend_q;
	logic       req_beat, rsp_beat;

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	// requests taken whose result beat has not gone out yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (req_beat && !rsp_beat) begin
			pend_q <= pend_q + 2'd1;
		end else if (!req_beat && rsp_beat) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_status))
		else $error("result beat changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_data == '0)
		else $error("nonzero data on a failed request");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result beat without a request");

	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 2'd0 || pend_q == 2'd1)
		else $error("more than one request outstanding");

endmodule

bind queue_from_two_stacks qts_chk u_qts_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data_out),
	.rsp_status (rsp.status)
);

FILE: bench/tb.sv
// testbench for queue_from_two_stacks: random insert/delete traffic checked against a fifo mirror
// depends on qts_pkg, qts_req_if, qts_rsp_if and the queue_from_two_stacks rtl
module tb;
	import qts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEM_TARGET = 950;

	typedef enum {SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_NOISE} segment_t;

	// tracks both stacks and queues the result each request should produce
	class fifo_mirror;
		typedef struct {
			logic signed [DATA_W-1:0] value;
			status_t                  status;
		} queue_result_t;

		logic signed [DATA_W-1:0] in_stk  [STACK_DEPTH];
		logic signed [DATA_W-1:0] out_stk [STACK_DEPTH];
		int in_cnt, out_cnt;
		queue_result_t pending_results[$];
		int errors, requests, pops, overflows, underflows, transfers;

		function new();
			in_cnt = 0;
			out_cnt = 0;
			errors = 0;
			requests = 0;
			pops = 0;
			overflows = 0;
			underflows = 0;
			transfers = 0;
		endfunction

		function void take_request(logic rt, logic signed [DATA_W-1:0] d);
			queue_result_t r;
			r.value = '0;
			r.status = ST_OK;
			requests++;
			if (rt == REQ_INSERT) begin
				if (in_cnt >= STACK_DEPTH) begin
					r.status = ST_OVERFLOW;
					overflows++;
				end else begin
					in_stk[in_cnt] = d;
					in_cnt++;
				end
			end else if (in_cnt == 0 && out_cnt == 0) begin
				r.status = ST_UNDERFLOW;
				underflows++;
			end else begin
				if (out_cnt == 0) begin
					transfers++;
					while (in_cnt > 0) begin
						in_cnt--;
						out_stk[out_cnt] = in_stk[in_cnt];
						out_cnt++;
					end
				end
				out_cnt--;
				r.value = out_stk[out_cnt];
				pops++;
			end
			pending_results.push_back(r);
		endfunction

		function void match_result(logic signed [DATA_W-1:0] d, status_t s);
			queue_result_t r;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat data_out %h status %0d", $time, d, s);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			if (d !== r.value) begin
				$display("%0t: data_out expected %h got %h", $time, r.value, d);
				errors++;
			end
			if (s !== r.status) begin
				$display("%0t: status expected %0d got %0d", $time, r.status, s);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles;
	int   sent;
	int   burst_left;
	bit   drained_once;
	fifo_mirror mirror = new();

	qts_req_if req ();
	qts_rsp_if rsp ();

	queue_from_two_stacks DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready)
			mirror.take_request(req.req_type, req.data_in);
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			mirror.match_result(rsp.data_out, rsp.status);
	end

	// receiver stall pattern: a random mode is held for a random phase, then redrawn
	initial begin
		int  mode;
		int  phase_left;
		logic rdy;
		mode = 0;
		phase_left = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(20, 120);
			end
			phase_left--;
			case (mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = ($urandom_range(0, 9) < 7);
			endcase
			rsp.ready <= rdy;
		end
	end

	// one beat, with the sender working in bursts separated by random gaps
	task automatic send_beat(input logic rt, input logic signed [DATA_W-1:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 3);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.req_type <= rt;
		req.data_in <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	task automatic run_segment(input segment_t kind, input int n);
		logic rt;
		repeat (n) begin
			case (kind)
				SEG_FILL:  rt = REQ_INSERT;
				SEG_DRAIN: rt = REQ_DELETE;
				SEG_NOISE: rt = 1'($urandom_range(0, 1));
				default:   rt = ($urandom_range(0, 99) < 62) ? REQ_INSERT : REQ_DELETE;
			endcase
			send_beat(rt, $urandom);
		end
	endtask

	initial begin
		segment_t kind;
		int pick;
		sent = 0;
		burst_left = 0;
		drained_once = 1'b0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.req_type <= REQ_INSERT;
		req.data_in <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, extreme values, transfer while input stack is refilled
		send_beat(REQ_DELETE, 32'h1234_5678);
		send_beat(REQ_INSERT, 32'sh7fff_ffff);
		send_beat(REQ_INSERT, 32'sh8000_0000);
		send_beat(REQ_INSERT, '0);
		send_beat(REQ_INSERT, '1);
		send_beat(REQ_INSERT, 32'h5555_5555);
		send_beat(REQ_INSERT, 32'haaaa_aaaa);
		send_beat(REQ_DELETE, '1);
		send_beat(REQ_INSERT, 32'h0000_0001);
		repeat (6) send_beat(REQ_DELETE, $urandom);
		send_beat(REQ_DELETE, '0);
		wait_drained();

		// full input stack, then overflow while the output stack still has room
		run_segment(SEG_FILL, STACK_DEPTH + 3);
		run_segment(SEG_DRAIN, 1);
		run_segment(SEG_FILL, STACK_DEPTH + 2);
		run_segment(SEG_DRAIN, 2 * STACK_DEPTH + 2);

		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)      kind = SEG_MIXED;
			else if (pick < 7) kind = SEG_FILL;
			else if (pick < 9) kind = SEG_DRAIN;
			else               kind = SEG_NOISE;
			case (kind)
				SEG_FILL:  run_segment(kind, $urandom_range(10, STACK_DEPTH + 6));
				SEG_DRAIN: run_segment(kind, $urandom_range(5, STACK_DEPTH + 20));
				default:   run_segment(kind, $urandom_range(10, 60));
			endcase
			if ((!drained_once && sent > ITEM_TARGET / 2) || $urandom_range(0, 5) == 0) begin
				wait_drained();
				drained_once = 1'b1;
			end
		end
		req.valid <= 1'b0;

		while (mirror.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d requests: %0d values returned, %0d transfers between stacks",
		         mirror.requests, mirror.pops, mirror.transfers);
		$display("%0d overflow and %0d underflow responses", mirror.overflows,
		         mirror.underflows);
		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/qts_pkg.sv
hdl/qts_req_if.sv
hdl/qts_rsp_if.sv
hdl/qts_ram.sv
hdl/queue_from_two_stacks.sv
hdl/qts_chk.sv
bench/tb.sv
